// File: hdl/bbg_pkg.sv
// ============================================================================
// bbg_pkg
// Shared cell and operation codes, column and status types, and the cell
// update rule for the grid step core.
// ============================================================================
`timescale 1ns / 1ps

package bbg_pkg;

    // Width of the row and column fields of an input item.
    localparam int IDX_W = 7;

    typedef logic [1:0] t_cell;
    localparam t_cell CELL_DEAD  = 2'd0;
    localparam t_cell CELL_DYING = 2'd1;
    localparam t_cell CELL_ALIVE = 2'd2;
    localparam t_cell CELL_SAT   = 2'd3;

    typedef logic [1:0] t_op;
    localparam t_op OP_WRITE   = 2'd0;
    localparam t_op OP_READ    = 2'd1;
    localparam t_op OP_ADVANCE = 2'd2;

    // Three vertically adjacent cells of one grid column.
    typedef struct packed {
        t_cell top;
        t_cell mid;
        t_cell bot;
    } t_col;

    localparam t_col COL_DEAD = '{top: CELL_DEAD, mid: CELL_DEAD, bot: CELL_DEAD};

    // Status of the generation engine as seen by the control.
    typedef struct packed {
        logic busy;
        logic done;
    } t_step_status;

    function automatic logic [3:0] f_alive(input t_cell c);
        f_alive = (c == CELL_ALIVE) ? 4'd1 : 4'd0;
    endfunction

    function automatic t_cell f_next_cell(input t_cell center, input logic [3:0] count);
        t_cell n;
        if (center == CELL_ALIVE) begin
            n = CELL_DYING;
        end else if (center == CELL_DYING) begin
            n = CELL_DEAD;
        end else begin
            n = (count == 4'd2) ? CELL_ALIVE : CELL_DEAD;
        end
        f_next_cell = n;
    endfunction

endpackage

// File: hdl/bbg_in_if.sv
// ============================================================================
// bbg_in_if
// Input channel: one operation item per valid/ready handshake.
// ============================================================================
`timescale 1ns / 1ps

interface bbg_in_if;
    logic                           valid;
    logic                           ready;
    bbg_pkg::t_op                   func;
    logic [bbg_pkg::IDX_W-1:0]      row_index;
    logic [bbg_pkg::IDX_W-1:0]      col_index;
    bbg_pkg::t_cell                 cell_value;

    modport source (output valid, output func, output row_index, output col_index,
                    output cell_value, input ready);
    modport sink   (input valid, input func, input row_index, input col_index,
                    input cell_value, output ready);
endinterface

// File: hdl/bbg_out_if.sv
// ============================================================================
// bbg_out_if
// Result channel: one result item per valid/ready handshake.
// ============================================================================
`timescale 1ns / 1ps

interface bbg_out_if;
    logic           valid;
    logic           ready;
    bbg_pkg::t_cell cell_state;
    bbg_pkg::t_op   op_echo;

    modport source (output valid, output cell_state, output op_echo, input ready);
    modport sink   (input valid, input cell_state, input op_echo, output ready);
endinterface

// File: hdl/bbg_ram.sv
// ============================================================================
// bbg_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ============================================================================
`timescale 1ns / 1ps

module bbg_ram #(
    parameter int WIDTH  = 2,
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

// File: hdl/bbg_stepper.sv
// ============================================================================
// bbg_stepper
// Generation engine: streams the live bank in raster order, keeps the two
// previous rows in a line buffer, slides a 3x3 window and writes each new
// cell into the spare bank.
// ============================================================================
`timescale 1ns / 1ps

module bbg_stepper #(
    parameter int GRID_SIZE = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic [2*$clog2(GRID_SIZE)-1:0]      o_rd_addr,
    input  bbg_pkg::t_cell                      i_rd_data,
    output logic                                o_wr_en,
    output logic [2*$clog2(GRID_SIZE)-1:0]      o_wr_addr,
    output bbg_pkg::t_cell                      o_wr_data,
    output bbg_pkg::t_step_status               o_status
);

    localparam int RW    = $clog2(GRID_SIZE);
    localparam int CNT_W = $clog2(GRID_SIZE + 1);
    localparam logic [CNT_W-1:0] G_CNT = CNT_W'(GRID_SIZE);

    // Scan position, one row and one column past the grid so that the last
    // row and column see dead cells below and to the right.
    logic             r_busy;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] r_col;

    // Stage 1: data from the bank and the line buffer arrives here.
    logic             r_s1_vld;
    logic             r_s1_last;
    logic [CNT_W-1:0] r_s1_row;
    logic [CNT_W-1:0] r_s1_col;

    bbg_pkg::t_col    r_win_left;
    bbg_pkg::t_col    r_win_mid;

    logic [3:0]       lb_q;
    logic             lb_we;
    logic [3:0]       lb_wdata;

    bbg_pkg::t_cell   n_x;
    bbg_pkg::t_cell   n_a;
    bbg_pkg::t_cell   n_b;
    bbg_pkg::t_col    n_inc;
    logic [3:0]       n_count;
    logic [CNT_W-1:0] n_out_row;
    logic [CNT_W-1:0] n_out_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_row  <= '0;
                r_col  <= '0;
            end else if (r_busy) begin
                if (r_col == G_CNT) begin
                    r_col <= '0;
                    if (r_row == G_CNT) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            r_s1_vld  <= r_busy;
            r_s1_last <= r_busy && (r_row == G_CNT) && (r_col == G_CNT);
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
        end
    end

    assign o_rd_addr = {r_row[RW-1:0], r_col[RW-1:0]};

    // Line buffer entry per column: {row just above, two rows above}.
    bbg_ram #(
        .WIDTH  (4),
        .ADDR_W (RW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (lb_we),
        .i_wr_addr (r_s1_col[RW-1:0]),
        .i_wr_data (lb_wdata),
        .i_rd_addr (r_col[RW-1:0]),
        .o_rd_data (lb_q)
    );

    always_comb begin
        n_x = ((r_s1_row < G_CNT) && (r_s1_col < G_CNT)) ? i_rd_data : bbg_pkg::CELL_DEAD;
        n_a = (r_s1_row == '0) ? bbg_pkg::CELL_DEAD : lb_q[3:2];
        n_b = (r_s1_row == '0) ? bbg_pkg::CELL_DEAD : lb_q[1:0];
        if (r_s1_col == G_CNT) begin
            n_inc = bbg_pkg::COL_DEAD;
        end else begin
            n_inc = '{top: n_b, mid: n_a, bot: n_x};
        end
        lb_we    = r_s1_vld && (r_s1_col < G_CNT);
        lb_wdata = {n_x, n_a};

        n_count = bbg_pkg::f_alive(r_win_left.top) + bbg_pkg::f_alive(r_win_left.mid)
                + bbg_pkg::f_alive(r_win_left.bot) + bbg_pkg::f_alive(r_win_mid.top)
                + bbg_pkg::f_alive(r_win_mid.bot)  + bbg_pkg::f_alive(n_inc.top)
                + bbg_pkg::f_alive(n_inc.mid)      + bbg_pkg::f_alive(n_inc.bot);
        n_out_row = r_s1_row - 1'b1;
        n_out_col = r_s1_col - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            if (r_s1_col == '0) begin
                r_win_left <= bbg_pkg::COL_DEAD;
            end else begin
                r_win_left <= r_win_mid;
            end
            r_win_mid <= n_inc;
        end
    end

    // The window center is the column to the left of the arriving one and
    // the row above it.
    assign o_wr_en   = r_s1_vld && (r_s1_row != '0) && (r_s1_col != '0);
    assign o_wr_addr = {n_out_row[RW-1:0], n_out_col[RW-1:0]};
    assign o_wr_data = bbg_pkg::f_next_cell(r_win_mid.mid, n_count);

    assign o_status.busy = r_busy || r_s1_vld;
    assign o_status.done = r_s1_vld && r_s1_last;

endmodule

// File: hdl/brians_brain_grid_step_core.sv
// ============================================================================
// brians_brain_grid_step_core
// Write or unused code: the result is registered at accept; read: the result
// is registered after the registered bank read; advance: the result waits for
// the one-cell-per-cycle raster scan of the live bank read port. One item is
// in flight at a time: writes can be taken every cycle as long as results are
// taken, but a read or an advance holds off the next item until its result is
// out. Reset clears both banks with a pass over every address, during which no
// item is accepted; bank a is then current.
// ============================================================================
`timescale 1ns / 1ps

module brians_brain_grid_step_core #(
    parameter int GRID_SIZE = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bbg_in_if.sink       i_in,
    bbg_out_if.source    o_out
);

    localparam int RW    = $clog2(GRID_SIZE);
    localparam int AW    = 2 * RW;
    localparam int CNT_W = $clog2(GRID_SIZE + 1);
    // Wide enough for both the index fields and the grid size itself.
    localparam int CMP_W = (CNT_W > bbg_pkg::IDX_W) ? CNT_W : bbg_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_ADV
    } t_state;

    t_state         r_state;
    logic [AW-1:0]  r_clr_addr;
    logic           r_cur;          // 0: bank a holds the live generation
    logic           r_start;
    logic           r_rd_inrange;
    logic           r_out_valid;
    bbg_pkg::t_cell r_out_state;
    bbg_pkg::t_op   r_out_op;

    logic [CMP_W-1:0] row_ext;
    logic [CMP_W-1:0] col_ext;
    logic             in_range;
    logic             in_acc;
    logic [AW-1:0]    cpu_addr;
    logic             cpu_we;
    bbg_pkg::t_cell   cpu_wdata;

    logic [AW-1:0]    rd_addr;
    bbg_pkg::t_cell   q_a;
    bbg_pkg::t_cell   q_b;
    bbg_pkg::t_cell   q_live;

    logic             we_a;
    logic             we_b;
    logic [AW-1:0]    wr_addr;
    bbg_pkg::t_cell   wr_data;

    logic [AW-1:0]          step_rd_addr;
    logic                   step_we;
    logic [AW-1:0]          step_wr_addr;
    bbg_pkg::t_cell         step_wr_data;
    bbg_pkg::t_step_status  step_status;

    // ------------------------------------------------------------------
    // Input decode. Indices at or beyond the grid size make a write do
    // nothing and a read return a dead cell.
    // ------------------------------------------------------------------
    assign row_ext  = CMP_W'(i_in.row_index);
    assign col_ext  = CMP_W'(i_in.col_index);
    assign in_range = (row_ext < CMP_W'(GRID_SIZE)) && (col_ext < CMP_W'(GRID_SIZE));
    assign cpu_addr = {row_ext[RW-1:0], col_ext[RW-1:0]};

    // Only one item is worked on at a time; the result register may still
    // hold the previous result if it leaves in the same cycle.
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;

    assign cpu_we    = in_acc && (i_in.func == bbg_pkg::OP_WRITE) && in_range;
    // A written value of three is stored as a dead cell.
    assign cpu_wdata = (i_in.cell_value == bbg_pkg::CELL_SAT) ? bbg_pkg::CELL_DEAD
                                                              : i_in.cell_value;

    // ------------------------------------------------------------------
    // Bank port steering. Both banks share the read address; the live one
    // is selected on the way out. Host writes go to the live bank, the
    // generation engine writes the spare bank, and the clearing pass
    // writes both.
    // ------------------------------------------------------------------
    assign rd_addr = (r_state == S_ADV) ? step_rd_addr : cpu_addr;
    assign q_live  = r_cur ? q_b : q_a;

    always_comb begin
        we_a    = 1'b0;
        we_b    = 1'b0;
        wr_addr = cpu_addr;
        wr_data = cpu_wdata;
        unique case (r_state)
            S_CLEAR: begin
                we_a    = 1'b1;
                we_b    = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = bbg_pkg::CELL_DEAD;
            end
            S_ADV: begin
                we_a    = step_we && r_cur;
                we_b    = step_we && !r_cur;
                wr_addr = step_wr_addr;
                wr_data = step_wr_data;
            end
            S_IDLE: begin
                we_a = cpu_we && !r_cur;
                we_b = cpu_we && r_cur;
            end
            default: begin
                we_a = 1'b0;
                we_b = 1'b0;
            end
        endcase
    end

    bbg_ram #(
        .WIDTH  (2),
        .ADDR_W (AW)
    ) u_bank_a (
        .i_clk     (i_clk),
        .i_wr_en   (we_a),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (q_a)
    );

    bbg_ram #(
        .WIDTH  (2),
        .ADDR_W (AW)
    ) u_bank_b (
        .i_clk     (i_clk),
        .i_wr_en   (we_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (q_b)
    );

    bbg_stepper #(
        .GRID_SIZE (GRID_SIZE)
    ) u_stepper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .o_rd_addr (step_rd_addr),
        .i_rd_data (q_live),
        .o_wr_en   (step_we),
        .o_wr_addr (step_wr_addr),
        .o_wr_data (step_wr_data),
        .o_status  (step_status)
    );

    // ------------------------------------------------------------------
    // Control. A write or an unused code completes at accept; a read waits
    // in S_READ for the registered bank read; an advance waits for the engine
    // and then swaps the banks.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cur       <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_out_op     <= i_in.func;
                        r_out_state  <= bbg_pkg::CELL_DEAD;
                        r_rd_inrange <= in_range;
                        unique case (i_in.func)
                            bbg_pkg::OP_READ: begin
                                r_state <= S_READ;
                            end
                            bbg_pkg::OP_ADVANCE: begin
                                r_state <= S_ADV;
                                r_start <= 1'b1;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_state <= r_rd_inrange ? q_live : bbg_pkg::CELL_DEAD;
                    r_state     <= S_IDLE;
                end
                S_ADV: begin
                    if (step_status.done) begin
                        r_cur       <= ~r_cur;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.cell_state = r_out_state;
    assign o_out.op_echo    = r_out_op;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_engine_only_in_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_status.busy |-> (r_state == S_ADV))
        else $error("generation engine active outside an advance");

    a_done_only_in_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_status.done |-> (r_state == S_ADV))
        else $error("generation done seen outside an advance");

    a_swap_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cur) |-> $past(step_status.done))
        else $error("banks swapped without a finished generation");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.func == bbg_pkg::OP_READ))
            |-> ##2 (r_out_valid && (r_out_op == bbg_pkg::OP_READ)))
        else $error("read item did not produce its result");

endmodule

// File: dv/brians_brain_grid_step_core_tb.sv
// ============================================================================
// brians_brain_grid_step_core_tb
// Drives write, read, advance and unused-code items into the grid step core.
// An internal double-banked grid model predicts each result item, and the
// results are compared in order against those predictions. The run moves
// through phases of sender idling and receiver stalling.
// ============================================================================
`timescale 1ns / 1ps

module brians_brain_grid_step_core_tb;

    localparam int GRID_SIZE   = 128;
    localparam int CELLS       = GRID_SIZE * GRID_SIZE;
    localparam int QUIET_LIMIT = 100000;
    localparam int DRAIN_WAIT  = 40;

    // Function code with no operation behind it.
    localparam bbg_pkg::t_op OP_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        bbg_pkg::t_cell cell_state;
        bbg_pkg::t_op   op_echo;
    } t_cell_result;

    logic clk;
    logic rst_n;

    bbg_in_if  in_ch ();
    bbg_out_if out_ch ();

    brians_brain_grid_step_core #(
        .GRID_SIZE(GRID_SIZE)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_idle_mode     idle_mode;
    bbg_pkg::t_cell grid_cells [2][CELLS];
    bit             live_bank;
    t_cell_result   pending_results[$];
    int             mismatches;
    int             quiet_cycles;
    t_cell_result   got_result;
    t_cell_result   want_result;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Grid model
    // ------------------------------------------------------------------------
    function automatic void clear_grid_model();
        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < CELLS; i++) begin
                grid_cells[b][i] = bbg_pkg::CELL_DEAD;
            end
        end
        live_bank = 1'b0;
    endfunction

    function automatic int alive_around(int row, int col);
        int count;
        int nr;
        int nc;
        count = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = row + dr;
                nc = col + dc;
                if ((dr != 0 || dc != 0) && nr >= 0 && nr < GRID_SIZE
                        && nc >= 0 && nc < GRID_SIZE) begin
                    if (grid_cells[live_bank][nr * GRID_SIZE + nc] == bbg_pkg::CELL_ALIVE) begin
                        count++;
                    end
                end
            end
        end
        return count;
    endfunction

    function automatic void next_generation();
        bbg_pkg::t_cell cur;
        bbg_pkg::t_cell nxt;
        for (int r = 0; r < GRID_SIZE; r++) begin
            for (int c = 0; c < GRID_SIZE; c++) begin
                cur = grid_cells[live_bank][r * GRID_SIZE + c];
                if (cur == bbg_pkg::CELL_ALIVE) begin
                    nxt = bbg_pkg::CELL_DYING;
                end else if (cur == bbg_pkg::CELL_DYING) begin
                    nxt = bbg_pkg::CELL_DEAD;
                end else begin
                    nxt = (alive_around(r, c) == 2) ? bbg_pkg::CELL_ALIVE
                                                    : bbg_pkg::CELL_DEAD;
                end
                grid_cells[!live_bank][r * GRID_SIZE + c] = nxt;
            end
        end
        live_bank = !live_bank;
    endfunction

    function automatic t_cell_result apply_grid_op(bbg_pkg::t_op op,
                                                   logic [bbg_pkg::IDX_W-1:0] row,
                                                   logic [bbg_pkg::IDX_W-1:0] col,
                                                   bbg_pkg::t_cell val);
        t_cell_result res;
        bit           in_grid;
        int           addr;
        res.cell_state = bbg_pkg::CELL_DEAD;
        res.op_echo    = op;
        in_grid = (int'(row) < GRID_SIZE) && (int'(col) < GRID_SIZE);
        addr    = int'(row) * GRID_SIZE + int'(col);
        case (op)
            bbg_pkg::OP_WRITE: begin
                if (in_grid) begin
                    grid_cells[live_bank][addr] = (val == bbg_pkg::CELL_SAT) ?
                                                  bbg_pkg::CELL_DEAD : val;
                end
            end
            bbg_pkg::OP_READ: begin
                if (in_grid) begin
                    res.cell_state = grid_cells[live_bank][addr];
                end
            end
            bbg_pkg::OP_ADVANCE: begin
                next_generation();
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: results are checked before the item accepted at the same edge
    // is predicted, since a result never leaves in its own acceptance cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got_result.cell_state = out_ch.cell_state;
                got_result.op_echo    = out_ch.op_echo;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual state %0d op %0d",
                             $time, got_result.cell_state, got_result.op_echo);
                    mismatches++;
                end else begin
                    want_result = pending_results.pop_front();
                    if (got_result.cell_state !== want_result.cell_state) begin
                        $display("%0t: cell_state mismatch: expected %0d, actual %0d",
                                 $time, want_result.cell_state, got_result.cell_state);
                        mismatches++;
                    end
                    if (got_result.op_echo !== want_result.op_echo) begin
                        $display("%0t: op_echo mismatch: expected %0d, actual %0d",
                                 $time, want_result.op_echo, got_result.op_echo);
                        mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                pending_results.push_back(apply_grid_op(in_ch.func, in_ch.row_index,
                                                        in_ch.col_index, in_ch.cell_value));
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result receiver with random stalls.
    always @(negedge clk) begin
        if (idle_mode == IDLE_RECEIVER) begin
            out_ch.ready <= ($urandom_range(99) >= 84);
        end else if (idle_mode == IDLE_BOTH) begin
            out_ch.ready <= ($urandom_range(99) >= 10);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic send_item(bbg_pkg::t_op op, int row, int col, bbg_pkg::t_cell val);
        int gap;
        int idle_pct;
        gap      = 0;
        idle_pct = (idle_mode == IDLE_SENDER) ? 84 : (idle_mode == IDLE_BOTH) ? 10 : 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        @(negedge clk);
        while (gap > 0) begin
            in_ch.valid      = 1'b0;
            in_ch.func       = bbg_pkg::t_op'($urandom_range(3));
            in_ch.row_index  = bbg_pkg::IDX_W'($urandom_range(GRID_SIZE - 1));
            in_ch.col_index  = bbg_pkg::IDX_W'($urandom_range(GRID_SIZE - 1));
            in_ch.cell_value = bbg_pkg::t_cell'($urandom_range(3));
            @(negedge clk);
            gap--;
        end
        in_ch.valid      = 1'b1;
        in_ch.func       = op;
        in_ch.row_index  = bbg_pkg::IDX_W'(row);
        in_ch.col_index  = bbg_pkg::IDX_W'(col);
        in_ch.cell_value = val;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
    endtask

    task automatic test_reset_state();
        send_item(bbg_pkg::OP_READ, 0, 0, bbg_pkg::CELL_DEAD);
        send_item(bbg_pkg::OP_READ, GRID_SIZE - 1, GRID_SIZE - 1, bbg_pkg::CELL_SAT);
    endtask

    // Corners written with alive, dying and three; value three must read back as dead.
    task automatic test_write_read_corners();
        send_item(bbg_pkg::OP_WRITE, 0, 0, bbg_pkg::CELL_ALIVE);
        send_item(bbg_pkg::OP_WRITE, GRID_SIZE - 1, GRID_SIZE - 1, bbg_pkg::CELL_DYING);
        send_item(bbg_pkg::OP_WRITE, 0, GRID_SIZE - 1, bbg_pkg::CELL_SAT);
        send_item(bbg_pkg::OP_WRITE, GRID_SIZE - 1, 0, bbg_pkg::CELL_ALIVE);
        send_item(bbg_pkg::OP_READ, 0, 0, bbg_pkg::CELL_DEAD);
        send_item(bbg_pkg::OP_READ, GRID_SIZE - 1, GRID_SIZE - 1, bbg_pkg::CELL_DEAD);
        send_item(bbg_pkg::OP_READ, 0, GRID_SIZE - 1, bbg_pkg::CELL_DEAD);
        send_item(bbg_pkg::OP_READ, GRID_SIZE - 1, 0, bbg_pkg::CELL_SAT);
    endtask

    task automatic test_unused_code();
        send_item(OP_UNUSED, GRID_SIZE - 1, GRID_SIZE - 1, bbg_pkg::CELL_SAT);
    endtask

    // Two alive cells touching a corner: the corner cell sees two alive
    // neighbors, the rest dead or beyond the edge, and so does the diagonal cell.
    task automatic test_generation_rules();
        send_item(bbg_pkg::OP_WRITE, 0, 0, bbg_pkg::CELL_DEAD);
        send_item(bbg_pkg::OP_WRITE, 0, 1, bbg_pkg::CELL_ALIVE);
        send_item(bbg_pkg::OP_WRITE, 1, 0, bbg_pkg::CELL_ALIVE);
        send_item(bbg_pkg::OP_ADVANCE, 0, 0, bbg_pkg::CELL_DEAD);
        send_item(bbg_pkg::OP_READ, 0, 0, bbg_pkg::CELL_DEAD);
        send_item(bbg_pkg::OP_READ, 1, 1, bbg_pkg::CELL_DEAD);
        send_item(bbg_pkg::OP_READ, 0, 1, bbg_pkg::CELL_DEAD);
        send_item(bbg_pkg::OP_READ, GRID_SIZE - 1, GRID_SIZE - 1, bbg_pkg::CELL_DEAD);
        send_item(bbg_pkg::OP_READ, GRID_SIZE - 1, 0, bbg_pkg::CELL_DEAD);
    endtask

    function automatic int pick_origin();
        case ($urandom_range(3))
            0:       return 0;
            1:       return GRID_SIZE - 4;
            default: return $urandom_range(GRID_SIZE - 4);
        endcase
    endfunction

    function automatic int clamp_index(int v);
        if (v < 0) begin
            return 0;
        end
        if (v > GRID_SIZE - 1) begin
            return GRID_SIZE - 1;
        end
        return v;
    endfunction

    // Small patterns in 4x4 windows, often at the edges, then at times an advance
    // and reads around the window. A tenth of the rounds are one scattered noise item.
    task automatic test_random_patterns(int n_items);
        int             sent;
        int             r0;
        int             c0;
        int             n_writes;
        int             n_reads;
        bbg_pkg::t_cell val;
        sent = 0;
        while (sent < n_items) begin
            idle_mode = t_idle_mode'((sent * 4) / n_items);
            if ($urandom_range(9) == 0) begin
                send_item(bbg_pkg::t_op'($urandom_range(3)), $urandom_range(GRID_SIZE - 1),
                          $urandom_range(GRID_SIZE - 1), bbg_pkg::t_cell'($urandom_range(3)));
                sent++;
            end else begin
                r0       = pick_origin();
                c0       = pick_origin();
                n_writes = $urandom_range(3, 7);
                n_reads  = $urandom_range(2, 5);
                repeat (n_writes) begin
                    val = ($urandom_range(99) < 60) ? bbg_pkg::CELL_ALIVE
                                                    : bbg_pkg::t_cell'($urandom_range(3));
                    send_item(bbg_pkg::OP_WRITE, r0 + $urandom_range(3),
                              c0 + $urandom_range(3), val);
                    sent++;
                end
                if ($urandom_range(99) < 45) begin
                    send_item(bbg_pkg::OP_ADVANCE, $urandom_range(GRID_SIZE - 1),
                              $urandom_range(GRID_SIZE - 1),
                              bbg_pkg::t_cell'($urandom_range(3)));
                    sent++;
                end
                repeat (n_reads) begin
                    send_item(bbg_pkg::OP_READ, clamp_index(r0 - 1 + $urandom_range(5)),
                              clamp_index(c0 - 1 + $urandom_range(5)),
                              bbg_pkg::t_cell'($urandom_range(3)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        idle_mode        = IDLE_NONE;
        mismatches       = 0;
        quiet_cycles     = 0;
        in_ch.valid      = 1'b0;
        in_ch.func       = bbg_pkg::OP_WRITE;
        in_ch.row_index  = '0;
        in_ch.col_index  = '0;
        in_ch.cell_value = bbg_pkg::CELL_DEAD;
        out_ch.ready     = 1'b1;
        clear_grid_model();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_write_read_corners();
        test_unused_code();
        test_generation_rules();
        test_random_patterns(80);

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
